### rtl/pldq_pkg.sv
// Shared types, constants and helper functions for the pooled linked dual queue.
// Used by pldq_ctrl, pldq_datapath and pooled_linked_dual_queue; depends on nothing.
`default_nettype none

package pldq_pkg;

    // Pool geometry. The null link is the value POOL_SIZE itself.
    localparam int POOL_SIZE = 1024;
    localparam int IDX_W     = $clog2(POOL_SIZE);
    localparam int LINK_W    = $clog2(POOL_SIZE + 1);

    // Fixed field widths of the stream payload.
    localparam int ENTRY_W   = 10;
    localparam int OP_W      = 3;
    localparam int CMP_W     = (LINK_W > ENTRY_W) ? LINK_W : ENTRY_W;

    localparam int S_TDATA_W = 16;
    localparam int S_TUSER_W = OP_W;
    localparam int M_TDATA_W = 16;
    localparam int M_TUSER_W = 1;

    typedef logic [LINK_W-1:0]    link_t;
    typedef logic [IDX_W-1:0]     idx_t;
    typedef logic [ENTRY_W-1:0]   entry_t;
    typedef logic [OP_W-1:0]      op_t;
    typedef logic [CMP_W-1:0]     cmp_t;
    typedef logic [S_TDATA_W-1:0] s_tdata_t;
    typedef logic [S_TUSER_W-1:0] s_tuser_t;
    typedef logic [M_TDATA_W-1:0] m_tdata_t;
    typedef logic [M_TUSER_W-1:0] m_tuser_t;

    localparam link_t LINK_NULL = link_t'(POOL_SIZE);
    localparam idx_t  IDX_LAST  = idx_t'(POOL_SIZE - 1);

    // Operation codes carried on s_tuser.
    localparam op_t OP_IDLE_ENQ = op_t'(0);
    localparam op_t OP_IDLE_DEQ = op_t'(1);
    localparam op_t OP_TODO_ENQ = op_t'(2);
    localparam op_t OP_TODO_DEQ = op_t'(3);
    localparam op_t OP_CLEAR    = op_t'(4);

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;    // a request is taken this cycle
        logic finish;    // complete the pending request and load the result
        logic clr_step;  // write one entry of the rebuild sweep
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_last;  // the sweep is at the last entry of the pool
    } dp_stat_t;

    function automatic logic is_null(input link_t l);
        return l >= LINK_NULL;
    endfunction

    function automatic logic entry_in_pool(input entry_t e);
        cmp_t w;
        w = cmp_t'(e);
        return w < cmp_t'(POOL_SIZE);
    endfunction

    function automatic link_t entry_to_link(input entry_t e);
        cmp_t w;
        w = cmp_t'(e);
        return w[LINK_W-1:0];
    endfunction

    function automatic entry_t link_to_entry(input link_t l);
        cmp_t w;
        w = cmp_t'(l);
        return w[ENTRY_W-1:0];
    endfunction

endpackage

`default_nettype wire

### rtl/pldq_ctrl.sv
// Controller state machine of the pooled linked dual queue.
// Depends on pldq_pkg; drives pldq_datapath through command and status structs.
`default_nettype none

module pldq_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire pldq_pkg::op_t      s_op,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output pldq_pkg::dp_cmd_t       dp_cmd,
    input  wire pldq_pkg::dp_stat_t dp_stat
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_FINISH = 2'd1;
    localparam logic [1:0] ST_CLEAR  = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       report_reg, report_next;
    logic       m_valid_reg, m_valid_next;
    logic       out_free;
    logic       accept;

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;

    always_comb begin
        dp_cmd.accept   = accept;
        dp_cmd.finish   = (state_reg == ST_FINISH) && out_free;
        dp_cmd.clr_step = (state_reg == ST_CLEAR);
    end

    always_comb begin
        state_next  = state_reg;
        report_next = report_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_op == pldq_pkg::OP_CLEAR) begin
                        state_next  = ST_CLEAR;
                        report_next = 1'b1;
                    end else begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            ST_CLEAR: begin
                if (dp_stat.clr_last) begin
                    state_next  = report_reg ? ST_FINISH : ST_IDLE;
                    report_next = 1'b0;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (dp_cmd.finish) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    // Reset starts the rebuild sweep without reporting a result.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            report_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            report_reg  <= report_next;
            m_valid_reg <= m_valid_next;
        end
    end

    a_accept_to_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && (s_op != pldq_pkg::OP_CLEAR) |=> state_reg == ST_FINISH)
        else $error("non-clear request did not move to the finish state");

    a_clear_reports: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR) && dp_stat.clr_last && report_reg
        |=> state_reg == ST_FINISH)
        else $error("clear request finished its sweep without a result");

    a_finish_waits: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FINISH) && !out_free |=> (state_reg == ST_FINISH) && m_valid_reg)
        else $error("finish state left while the result register was occupied");

endmodule

`default_nettype wire

### rtl/pldq_datapath.sv
// Datapath of the pooled linked dual queue: link memory, list pointers,
// rebuild sweep counter and result register. Depends on pldq_pkg.
`default_nettype none

module pldq_datapath (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire pldq_pkg::s_tdata_t   s_tdata,
    input  wire pldq_pkg::s_tuser_t   s_tuser,
    input  wire pldq_pkg::dp_cmd_t    dp_cmd,
    output pldq_pkg::dp_stat_t        dp_stat,
    output pldq_pkg::m_tdata_t        m_tdata,
    output pldq_pkg::m_tuser_t        m_tuser
);

    pldq_pkg::link_t link_mem [pldq_pkg::POOL_SIZE];

    pldq_pkg::link_t idle_head_reg, idle_head_next;
    pldq_pkg::link_t idle_tail_reg, idle_tail_next;
    pldq_pkg::link_t todo_head_reg, todo_head_next;
    pldq_pkg::link_t todo_tail_reg, todo_tail_next;
    pldq_pkg::idx_t  clr_cnt_reg, clr_cnt_next;

    pldq_pkg::op_t   op_reg;
    pldq_pkg::link_t entry_reg;
    logic            entry_ok_reg;
    logic            found_reg;
    pldq_pkg::link_t removed_reg;
    pldq_pkg::link_t rd_data_reg;

    logic            out_found_reg;
    pldq_pkg::entry_t out_index_reg;
    logic            out_idle_empty_reg;
    logic            out_todo_empty_reg;

    pldq_pkg::op_t    op_in;
    pldq_pkg::entry_t entry_in;
    logic             in_todo, in_enq, in_deq, in_ok;
    pldq_pkg::link_t  in_head, in_tail;

    logic             fin_todo, fin_enq, fin_deq;
    pldq_pkg::link_t  fin_head, fin_tail, new_head, new_tail, cand;

    logic             mem_we, mem_re;
    pldq_pkg::idx_t   mem_waddr, mem_raddr;
    pldq_pkg::link_t  mem_wdata;

    // Decode of the incoming request.
    assign op_in    = s_tuser;
    assign entry_in = s_tdata[pldq_pkg::ENTRY_W-1:0];
    assign in_todo  = (op_in == pldq_pkg::OP_TODO_ENQ) || (op_in == pldq_pkg::OP_TODO_DEQ);
    assign in_enq   = (op_in == pldq_pkg::OP_IDLE_ENQ) || (op_in == pldq_pkg::OP_TODO_ENQ);
    assign in_deq   = (op_in == pldq_pkg::OP_IDLE_DEQ) || (op_in == pldq_pkg::OP_TODO_DEQ);
    assign in_ok    = pldq_pkg::entry_in_pool(entry_in);
    assign in_head  = in_todo ? todo_head_reg : idle_head_reg;
    assign in_tail  = in_todo ? todo_tail_reg : idle_tail_reg;

    // Decode of the pending request.
    assign fin_todo = (op_reg == pldq_pkg::OP_TODO_ENQ) || (op_reg == pldq_pkg::OP_TODO_DEQ);
    assign fin_enq  = (op_reg == pldq_pkg::OP_IDLE_ENQ) || (op_reg == pldq_pkg::OP_TODO_ENQ);
    assign fin_deq  = (op_reg == pldq_pkg::OP_IDLE_DEQ) || (op_reg == pldq_pkg::OP_TODO_DEQ);
    assign fin_head = fin_todo ? todo_head_reg : idle_head_reg;
    assign fin_tail = fin_todo ? todo_tail_reg : idle_tail_reg;

    assign dp_stat.clr_last = (clr_cnt_reg == pldq_pkg::IDX_LAST);

    // One write port: the sweep, the old tail's link at accept, or the new
    // tail's null link at finish. The tail link goes first so that an entry
    // appended behind itself ends up null.
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = clr_cnt_reg;
        mem_wdata = pldq_pkg::LINK_NULL;
        if (dp_cmd.clr_step) begin
            mem_we    = 1'b1;
            mem_waddr = clr_cnt_reg;
            mem_wdata = pldq_pkg::link_t'(clr_cnt_reg) + pldq_pkg::link_t'(1);
        end else if (dp_cmd.accept && in_enq && in_ok && !pldq_pkg::is_null(in_tail)) begin
            mem_we    = 1'b1;
            mem_waddr = in_tail[pldq_pkg::IDX_W-1:0];
            mem_wdata = pldq_pkg::entry_to_link(entry_in);
        end else if (dp_cmd.finish && fin_enq && entry_ok_reg) begin
            mem_we    = 1'b1;
            mem_waddr = entry_reg[pldq_pkg::IDX_W-1:0];
            mem_wdata = pldq_pkg::LINK_NULL;
        end
    end

    assign mem_re    = dp_cmd.accept && in_deq && !pldq_pkg::is_null(in_head);
    assign mem_raddr = in_head[pldq_pkg::IDX_W-1:0];

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            link_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_data_reg <= link_mem[mem_raddr];
        end
    end

    // New pointers of the list that the pending request works on.
    always_comb begin
        new_head = fin_head;
        new_tail = fin_tail;
        cand     = found_reg ? rd_data_reg : fin_head;
        if (fin_enq && entry_ok_reg) begin
            if (pldq_pkg::is_null(fin_tail)) begin
                new_head = entry_reg;
            end
            new_tail = entry_reg;
        end else if (fin_deq) begin
            if (pldq_pkg::is_null(cand)) begin
                new_head = pldq_pkg::LINK_NULL;
                new_tail = pldq_pkg::LINK_NULL;
            end else begin
                new_head = cand;
            end
        end
    end

    always_comb begin
        idle_head_next = idle_head_reg;
        idle_tail_next = idle_tail_reg;
        todo_head_next = todo_head_reg;
        todo_tail_next = todo_tail_reg;
        if (dp_cmd.accept && (op_in == pldq_pkg::OP_CLEAR)) begin
            idle_head_next = '0;
            idle_tail_next = pldq_pkg::link_t'(pldq_pkg::IDX_LAST);
            todo_head_next = pldq_pkg::LINK_NULL;
            todo_tail_next = pldq_pkg::LINK_NULL;
        end else if (dp_cmd.finish) begin
            if (fin_todo) begin
                todo_head_next = new_head;
                todo_tail_next = new_tail;
            end else begin
                idle_head_next = new_head;
                idle_tail_next = new_tail;
            end
        end
    end

    always_comb begin
        clr_cnt_next = clr_cnt_reg;
        if (dp_cmd.clr_step) begin
            clr_cnt_next = dp_stat.clr_last ? '0 : clr_cnt_reg + pldq_pkg::idx_t'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idle_head_reg <= '0;
            idle_tail_reg <= pldq_pkg::link_t'(pldq_pkg::IDX_LAST);
            todo_head_reg <= pldq_pkg::LINK_NULL;
            todo_tail_reg <= pldq_pkg::LINK_NULL;
            clr_cnt_reg   <= '0;
        end else begin
            idle_head_reg <= idle_head_next;
            idle_tail_reg <= idle_tail_next;
            todo_head_reg <= todo_head_next;
            todo_tail_reg <= todo_tail_next;
            clr_cnt_reg   <= clr_cnt_next;
        end
    end

    // Request capture and result register.
    always_ff @(posedge aclk) begin
        if (dp_cmd.accept) begin
            op_reg       <= op_in;
            entry_reg    <= pldq_pkg::entry_to_link(entry_in);
            entry_ok_reg <= in_ok;
            found_reg    <= in_deq && !pldq_pkg::is_null(in_head);
            removed_reg  <= in_head;
        end
        if (dp_cmd.finish) begin
            out_found_reg      <= found_reg;
            out_index_reg      <= found_reg ? pldq_pkg::link_to_entry(removed_reg) : '0;
            out_idle_empty_reg <= pldq_pkg::is_null(idle_head_next);
            out_todo_empty_reg <= pldq_pkg::is_null(todo_head_next);
        end
    end

    assign m_tdata = pldq_pkg::m_tdata_t'({out_todo_empty_reg, out_idle_empty_reg, out_index_reg});
    assign m_tuser = out_found_reg;

    a_idle_pair: assert property (@(posedge aclk) disable iff (!aresetn)
        pldq_pkg::is_null(idle_head_reg) == pldq_pkg::is_null(idle_tail_reg))
        else $error("idle list head and tail disagree on emptiness");

    a_todo_pair: assert property (@(posedge aclk) disable iff (!aresetn)
        pldq_pkg::is_null(todo_head_reg) == pldq_pkg::is_null(todo_tail_reg))
        else $error("to-do list head and tail disagree on emptiness");

    a_link_range: assert property (@(posedge aclk) disable iff (!aresetn)
        dp_cmd.finish && found_reg |-> rd_data_reg <= pldq_pkg::LINK_NULL)
        else $error("link read from memory is neither an entry nor null");

endmodule

`default_nettype wire

### rtl/pooled_linked_dual_queue.sv
// Top level of the pooled linked dual queue: an idle list and a to-do list
// threaded through one shared link memory. Depends on pldq_pkg, pldq_ctrl
// and pldq_datapath.
//
// Usage: each request on the s_ channel carries an operation in s_tuser and
// an entry index in s_tdata. Every request gives exactly one result on the
// m_ channel: found in m_tuser, and the removed entry and both empty flags in
// m_tdata. Enqueues and dequeues do the first link-memory access in the
// accept cycle (the old tail's link write, or the head's link read); the
// finish state then finishes the pointers, loads the result register and
// raises m_tvalid. A clear first runs the sweep that rewrites one link-memory
// entry a cycle and then goes through the finish state; unknown operation
// codes go straight to the finish state and change no list.
// One request is worked on at a time; the single write port of the link
// memory sets the pace. After reset the same sweep runs with s_tready low
// and gives no result. If the receiver stalls, the result register holds
// the finished result, a new request is still taken, and that request
// waits in its finish cycle until the result register is free.
`default_nettype none

module pooled_linked_dual_queue (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire pldq_pkg::s_tdata_t s_tdata,  // [9:0] entry_index, rest zero
    input  wire pldq_pkg::s_tuser_t s_tuser,  // [2:0] operation
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output pldq_pkg::m_tdata_t      m_tdata,  // [9:0] removed_index, [10] idle_empty,
                                              // [11] todo_empty, rest zero
    output pldq_pkg::m_tuser_t      m_tuser   // [0] found
);

    // Commands run from the controller to the datapath; the datapath reports
    // the end of the rebuild sweep back.
    pldq_pkg::dp_cmd_t  dp_cmd;
    pldq_pkg::dp_stat_t dp_stat;

    pldq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_op     (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .dp_cmd   (dp_cmd),
        .dp_stat  (dp_stat)
    );

    pldq_datapath u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .dp_cmd  (dp_cmd),
        .dp_stat (dp_stat),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

endmodule

`default_nettype wire

### dv/pldq_reply_checker.sv
// Checker for the pooled linked dual queue: watches both stream channels,
// predicts the reply of each accepted request and compares it field by field.
// Depends on pldq_pkg for the stream types, the pool size and the operation codes.
module pldq_reply_checker (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    input  logic               s_tready,
    input  pldq_pkg::s_tdata_t s_tdata,   // [9:0] entry_index, rest zero
    input  pldq_pkg::s_tuser_t s_tuser,   // [2:0] operation
    input  logic               m_tvalid,
    input  logic               m_tready,
    input  pldq_pkg::m_tdata_t m_tdata,   // [9:0] removed_index, [10] idle_empty,
                                          // [11] todo_empty, rest zero
    input  pldq_pkg::m_tuser_t m_tuser,   // [0] found
    output int                 fail_count,
    output int                 pending_count
);
    import pldq_pkg::*;

    typedef struct packed {
        logic   found;
        entry_t removed;
        logic   idle_empty;
        logic   todo_empty;
    } reply_t;

    // Private copy of the shared link memory and the four list pointers.
    link_t  chain [POOL_SIZE];
    link_t  free_head, free_tail, work_head, work_tail;
    reply_t awaited_replies [$];

    initial begin
        fail_count    = 0;
        pending_count = 0;
    end

    function automatic void rebuild_pool();
        for (int i = 0; i < POOL_SIZE; i++) begin
            chain[i] = link_t'(i + 1);
        end
        chain[POOL_SIZE-1] = LINK_NULL;
        free_head = link_t'(0);
        free_tail = link_t'(POOL_SIZE - 1);
        work_head = LINK_NULL;
        work_tail = LINK_NULL;
    endfunction

    // Appends an entry; the links are written even if the entry already sits
    // in a list, which may cut that list short.
    function automatic void push_entry(input logic to_work, input entry_t e);
        link_t tail;
        tail = to_work ? work_tail : free_tail;
        if (int'(e) >= POOL_SIZE) begin
            return;
        end
        if (tail < LINK_NULL) begin
            chain[tail] = link_t'(e);
        end else if (to_work) begin
            work_head = link_t'(e);
        end else begin
            free_head = link_t'(e);
        end
        chain[e] = LINK_NULL;
        if (to_work) begin
            work_tail = link_t'(e);
        end else begin
            free_tail = link_t'(e);
        end
    endfunction

    function automatic logic pop_entry(input logic from_work, output link_t taken);
        link_t head;
        logic  got;
        head  = from_work ? work_head : free_head;
        got   = 1'b0;
        taken = '0;
        if (head < LINK_NULL) begin
            taken = head;
            head  = chain[head];
            got   = 1'b1;
        end
        if (from_work) begin
            work_head = head;
        end else begin
            free_head = head;
        end
        if (head >= LINK_NULL) begin
            if (from_work) begin
                work_head = LINK_NULL;
                work_tail = LINK_NULL;
            end else begin
                free_head = LINK_NULL;
                free_tail = LINK_NULL;
            end
        end
        return got;
    endfunction

    function automatic reply_t serve_request(input op_t op, input entry_t e);
        reply_t r;
        link_t  taken;
        r     = '0;
        taken = '0;
        case (op)
            OP_IDLE_ENQ: push_entry(1'b0, e);
            OP_IDLE_DEQ: r.found = pop_entry(1'b0, taken);
            OP_TODO_ENQ: push_entry(1'b1, e);
            OP_TODO_DEQ: r.found = pop_entry(1'b1, taken);
            OP_CLEAR:    rebuild_pool();
            default:     ;
        endcase
        r.removed    = r.found ? entry_t'(taken) : '0;
        r.idle_empty = (free_head >= LINK_NULL);
        r.todo_empty = (work_head >= LINK_NULL);
        return r;
    endfunction

    always @(posedge aclk) begin
        reply_t want;
        reply_t got;
        if (!aresetn) begin
            rebuild_pool();
            awaited_replies.delete();
        end else begin
            if (s_tvalid && s_tready) begin
                awaited_replies.push_back(serve_request(s_tuser, s_tdata[ENTRY_W-1:0]));
            end
            if (m_tvalid && m_tready) begin
                got.found      = m_tuser[0];
                got.removed    = m_tdata[ENTRY_W-1:0];
                got.idle_empty = m_tdata[ENTRY_W];
                got.todo_empty = m_tdata[ENTRY_W+1];
                if (awaited_replies.size() == 0) begin
                    $error("reply with no request outstanding: tdata %h tuser %h",
                           m_tdata, m_tuser);
                    fail_count++;
                end else begin
                    want = awaited_replies.pop_front();
                    if (got.found !== want.found) begin
                        $error("found: expected %0d, actual %0d", want.found, got.found);
                        fail_count++;
                    end
                    if (got.removed !== want.removed) begin
                        $error("removed_index: expected %0d, actual %0d",
                               want.removed, got.removed);
                        fail_count++;
                    end
                    if (got.idle_empty !== want.idle_empty) begin
                        $error("idle_empty: expected %0d, actual %0d",
                               want.idle_empty, got.idle_empty);
                        fail_count++;
                    end
                    if (got.todo_empty !== want.todo_empty) begin
                        $error("todo_empty: expected %0d, actual %0d",
                               want.todo_empty, got.todo_empty);
                        fail_count++;
                    end
                end
            end
        end
        pending_count = awaited_replies.size();
    end

endmodule

### dv/tb_pooled_linked_dual_queue.sv
// Top of the pooled linked dual queue testbench: clock, reset, request stimulus,
// receiver back-pressure, watchdog and verdict. Depends on pldq_pkg, the block
// pooled_linked_dual_queue and the checker pldq_reply_checker.
module tb_pooled_linked_dual_queue;
    import pldq_pkg::*;

    // A clear sweeps the whole pool, so the longest quiet stretch of a correct
    // run is about one sweep plus the longest gaps on both sides. The limit
    // allows several times that.
    localparam int MAX_GAP      = 60;
    localparam int QUIET_LIMIT  = 8 * (POOL_SIZE + 2 + 2 * MAX_GAP);
    localparam int RANDOM_COUNT = 1600;
    localparam int TAIL_CYCLES  = 16;

    logic       aclk;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    s_tdata_t   s_tdata  = '0;     // [9:0] entry_index, rest zero
    s_tuser_t   s_tuser  = '0;     // [2:0] operation
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    m_tdata_t   m_tdata;           // [9:0] removed_index, [10] idle_empty, [11] todo_empty
    m_tuser_t   m_tuser;           // [0] found

    int         fail_count;
    int         pending_count;
    int         quiet_cycles = 0;

    // Idling switches; the stimulus process changes them between blocks of
    // requests so that some stretches run with no gaps at all.
    logic       tx_idle_en = 1'b1;
    logic       rx_stall_en = 1'b1;

    pooled_linked_dual_queue DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    pldq_reply_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Gap lengths: mostly from the short range, now and then from the long range up to MAX_GAP.
    function automatic int gap_len();
        if ($urandom_range(0, 99) < 85) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, MAX_GAP);
    endfunction

    // Presents one request, holds it until the block takes it, and then may
    // leave the channel idle for a while. When no gap follows, tvalid simply
    // stays high into the next request, so it is never lowered and raised in
    // the same step.
    task automatic issue_request(input op_t op, input entry_t e);
        int n;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= s_tdata_t'(e);
        do @(posedge aclk); while (!s_tready);
        if (tx_idle_en && $urandom_range(0, 99) < 30) begin
            n = gap_len();
            s_tvalid <= 1'b0;
            repeat (n) @(posedge aclk);
        end
    endtask

    // Holds the sender off until every request has delivered its reply. The
    // counters are read at the falling edge, away from the checker's update.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (pending_count != 0);
        @(posedge aclk);
    endtask

    // Receiver: random stalls on m_tready, independent of m_tvalid, so they
    // fall on every phase of the block's work.
    initial begin : receiver
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge aclk);
            if (stall_left == 0 && rx_stall_en && $urandom_range(0, 99) < 25) begin
                stall_left = gap_len();
            end
            if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Watchdog: any cycle that moves a request or a reply counts as progress.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        int     r;
        int     window;
        op_t    op;
        entry_t e;

        // Reset once; the block then runs its pool sweep with s_tready low.
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part. After reset the idle list holds every entry in order
        // and the to-do list is empty.
        issue_request(OP_IDLE_DEQ, entry_t'(0));       // takes entry 0
        issue_request(OP_TODO_DEQ, entry_t'(0));       // to-do list empty: not found
        issue_request(OP_TODO_ENQ, entry_t'('1));      // highest entry, also the idle tail
        issue_request(OP_TODO_ENQ, entry_t'(0));
        issue_request(OP_TODO_DEQ, entry_t'(0));
        issue_request(OP_TODO_DEQ, entry_t'(0));       // empties the to-do list
        issue_request(OP_TODO_DEQ, entry_t'(0));       // dequeue from an empty list
        // Appending the idle tail to its own list again rewrites the same link.
        issue_request(OP_IDLE_ENQ, entry_t'('1));
        // An entry that still sits in the idle list goes onto the to-do list,
        // which cuts the idle list short right after it.
        issue_request(OP_TODO_ENQ, entry_t'(5));
        repeat (5) issue_request(OP_IDLE_DEQ, entry_t'(0));  // 1..5, then idle is empty
        issue_request(OP_IDLE_DEQ, entry_t'(0));       // idle list empty: not found
        issue_request(OP_IDLE_ENQ, entry_t'(682));     // alternating bit pattern
        issue_request(OP_TODO_ENQ, entry_t'(341));     // the complementary pattern
        // Undefined operation codes change nothing and report the flags.
        issue_request(op_t'(OP_CLEAR + 1), entry_t'('1));
        issue_request(op_t'(OP_CLEAR + 2), entry_t'(0));
        issue_request(op_t'('1), entry_t'(0));
        issue_request(OP_CLEAR, entry_t'('1));
        wait_drained();
        issue_request(OP_IDLE_DEQ, entry_t'(0));       // back to entry 0 after the clear
        issue_request(OP_TODO_DEQ, entry_t'(0));
        issue_request(OP_IDLE_ENQ, entry_t'(0));
        wait_drained();

        // Random part. Entries are mostly drawn from a narrow window, so the
        // same few entries bounce between the lists, cut them short and empty
        // them often; the rest spread over the whole index range.
        window = 0;
        for (int i = 0; i < RANDOM_COUNT; i++) begin
            if (i % 100 == 0) begin
                r           = $urandom_range(0, 3);
                tx_idle_en  = r[0];
                rx_stall_en = r[1];
                window      = $urandom_range(0, POOL_SIZE - 1);
            end
            r = $urandom_range(0, 99);
            if (r < 2) begin
                op = OP_CLEAR;
            end else if (r < 5) begin
                op = op_t'($urandom_range(int'(OP_CLEAR) + 1, int'(op_t'('1))));
            end else begin
                op = op_t'($urandom_range(int'(OP_IDLE_ENQ), int'(OP_TODO_DEQ)));
            end
            r = $urandom_range(0, 99);
            if (r < 70) begin
                e = entry_t'(window + $urandom_range(0, 15));
            end else if (r < 75) begin
                e = ($urandom_range(0, 1) == 0) ? entry_t'(0) : entry_t'('1);
            end else begin
                e = entry_t'($urandom_range(0, POOL_SIZE - 1));
            end
            issue_request(op, e);
            if ($urandom_range(0, 99) == 0) begin
                wait_drained();
            end
        end

        // Let every reply arrive, then watch a little longer for stray ones.
        tx_idle_en = 1'b0;
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        @(negedge aclk);
        if (fail_count == 0 && pending_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
